FILE: src/cpt_pkg.sv
// Package: shared types and constants for the code page translator.
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

  localparam logic [7:0] FRAME_BASE_RESET = 8'd11;

  typedef struct packed {
    logic [15:0] phys_addr;
    logic        same_page;
    logic        page_fault;
    logic [7:0]  fill_source_page;
    logic [7:0]  fill_frame;
  } cpt_result_t;

endpackage
`default_nettype wire

FILE: src/cpt_ifs.sv
// Interfaces: request, response and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface cpt_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_addr;
  modport source (output valid, output code_addr, input ready);
  modport sink (input valid, input code_addr, output ready);
endinterface

interface cpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] phys_addr;
  logic        same_page;
  logic        page_fault;
  logic [7:0]  fill_source_page;
  logic [7:0]  fill_frame;
  modport source (output valid, output phys_addr, output same_page, output page_fault,
                  output fill_source_page, output fill_frame, input ready);
  modport sink (input valid, input phys_addr, input same_page, input page_fault,
                input fill_source_page, input fill_frame, output ready);
endinterface

interface cpt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/code_page_translate_fifo.sv
// Top level: code page translator with FIFO page replacement.
//
//  channel  dir  signals                                            role
//  req      in   valid ready code_addr                              virtual address
//  rsp      out  valid ready phys_addr same_page page_fault         translated word
//                fill_source_page fill_frame
//  cfg      in   valid ready data                                   frame_base write
//
// Same-page word: result registered at accept, then taken by a free output register.
// Table scan: one compare per cycle until the first match, at most TABLE_ENTRIES;
// the result is registered at the last compare, then taken by a free output register.
// The sequencer holds one word; req.ready is high only while it is idle, and a
// finished word waits in the sequencer while the output register is held.
// rst clears the table, last page/frame, pointer and sets frame_base to 11.
`timescale 1ns / 1ps
`default_nettype none
module code_page_translate_fifo import cpt_pkg::*; #(
  parameter int TABLE_ENTRIES = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cpt_req_if.sink    req,
  cpt_rsp_if.source  rsp,
  cpt_cfg_if.sink    cfg
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [7:0]       frame_base;
  logic             seq_idle;
  logic             seq_rdy;
  logic             take;
  cpt_result_t      seq_result;
  cpt_result_t      out_word;
  logic             out_valid;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       key;
  logic             hit;
  logic             we;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_page;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= FRAME_BASE_RESET;
    end else if (cfg.valid) begin
      frame_base <= cfg.data;
    end
  end

  assign req.ready = seq_idle;
  assign take      = seq_rdy && (!out_valid || rsp.ready);

  cpt_seq #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (req.valid),
    .code_addr  (req.code_addr),
    .frame_base (frame_base),
    .idle       (seq_idle),
    .rdy        (seq_rdy),
    .take       (take),
    .result     (seq_result),
    .rd_idx     (rd_idx),
    .key        (key),
    .hit        (hit),
    .we         (we),
    .wr_idx     (wr_idx),
    .wr_page    (wr_page)
  );

  cpt_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (rd_idx),
    .key     (key),
    .hit     (hit),
    .we      (we),
    .wr_idx  (wr_idx),
    .wr_page (wr_page)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_word <= seq_result;
  end

  assign rsp.valid            = out_valid;
  assign rsp.phys_addr        = out_word.phys_addr;
  assign rsp.same_page        = out_word.same_page;
  assign rsp.page_fault       = out_word.page_fault;
  assign rsp.fill_source_page = out_word.fill_source_page;
  assign rsp.fill_frame       = out_word.fill_frame;

endmodule
`default_nettype wire

FILE: src/cpt_table.sv
// Page table storage with the single shared page comparator.
`timescale 1ns / 1ps
`default_nettype none
module cpt_table #(
  parameter int ENTRIES = 4,
  parameter int IDX_W   = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_idx,
  input  wire logic [7:0]       key,
  output logic                  hit,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [7:0]       wr_page
);

  logic [7:0] entries [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) entries[i] <= 8'd0;
    end else if (we) begin
      entries[wr_idx] <= wr_page;
    end
  end

  assign hit = (entries[rd_idx] == key);

endmodule
`default_nettype wire

FILE: src/cpt_seq.sv
// Sequencer: same-page check, table scan, FIFO replacement and result build.
`timescale 1ns / 1ps
`default_nettype none
module cpt_seq import cpt_pkg::*; #(
  parameter int ENTRIES = 4,
  parameter int IDX_W   = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [15:0]      code_addr,
  input  wire logic [7:0]       frame_base,
  output logic                  idle,
  output logic                  rdy,
  input  wire logic             take,
  output cpt_result_t           result,
  output logic [IDX_W-1:0]      rd_idx,
  output logic [7:0]            key,
  input  wire logic             hit,
  output logic                  we,
  output logic [IDX_W-1:0]      wr_idx,
  output logic [7:0]            wr_page
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  logic [1:0]       state;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] ptr;
  logic [7:0]       last_page;
  logic [7:0]       last_frame;
  logic [7:0]       page;
  logic [7:0]       offset;
  logic             scan_end;
  logic [IDX_W-1:0] sel_idx;
  logic [7:0]       frame_sum;

  assign scan_end  = (state == S_SCAN) && (hit || (idx == IDX_LAST));
  // hit gives base + scan index, miss gives base + replacement slot
  assign sel_idx   = hit ? idx : ptr;
  assign frame_sum = frame_base + 8'(sel_idx);

  assign idle    = (state == S_IDLE);
  assign rdy     = (state == S_DONE);
  assign rd_idx  = idx;
  assign key     = page;
  assign we      = scan_end && !hit;
  assign wr_idx  = ptr;
  assign wr_page = page;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      ptr        <= '0;
      last_page  <= 8'd0;
      last_frame <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (start) begin
            state <= (code_addr[15:8] == last_page) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state      <= S_DONE;
            last_page  <= page;
            last_frame <= frame_sum;
            if (!hit) ptr <= (ptr == IDX_LAST) ? '0 : ptr + 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (idle && start) begin
      page   <= code_addr[15:8];
      offset <= code_addr[7:0];
      result.phys_addr        <= {last_frame, code_addr[7:0]};
      result.same_page        <= 1'b1;
      result.page_fault       <= 1'b0;
      result.fill_source_page <= 8'd0;
      result.fill_frame       <= 8'd0;
    end else if (scan_end) begin
      result.phys_addr        <= {frame_sum, offset};
      result.same_page        <= 1'b0;
      result.page_fault       <= !hit;
      result.fill_source_page <= hit ? 8'd0 : page;
      result.fill_frame       <= hit ? 8'd0 : frame_sum;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (rdy && !take) |=> $stable(result))
    else $error("result changed while waiting");

  a_fault_frame: assert property (@(posedge clk) disable iff (rst)
    (rdy && result.page_fault) |-> (result.fill_frame == result.phys_addr[15:8]))
    else $error("fill frame differs from translated frame");

  a_same_no_fault: assert property (@(posedge clk) disable iff (rst)
    rdy |-> !(result.same_page && result.page_fault))
    else $error("same page result flagged a fault");

  a_ptr_only_on_fill: assert property (@(posedge clk) disable iff (rst)
    !we |=> (ptr == $past(ptr)))
    else $error("replacement pointer moved without a table write");

endmodule
`default_nettype wire

FILE: sim/code_page_translate_fifo_test.sv
// Testbench for the code page translator: directed table plus random traffic, scoreboarded.
`timescale 1ns / 1ps
module code_page_translate_fifo_test;
  import cpt_pkg::*;

  localparam int ENTRIES       = 4;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 300;
  localparam int POOL_PAGES    = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [15:0] addr;
    logic        pinned;
    cpt_result_t res;
  } xlat_row_t;

  logic clk;
  logic rst;

  cpt_req_if req_ch ();
  cpt_rsp_if rsp_ch ();
  cpt_cfg_if cfg_ch ();

  code_page_translate_fifo #(.TABLE_ENTRIES(ENTRIES)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // translator state mirror
  logic [7:0]  page_tbl [ENTRIES];
  logic [7:0]  prev_page;
  logic [7:0]  prev_frame;
  int          fill_ptr;
  logic [7:0]  frame_base_q;

  cpt_result_t pending_xlat [$];
  xlat_row_t   pinned_q [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  logic [7:0]  last_sent_page;
  logic [7:0]  page_pool [POOL_PAGES];

  // after reset: page 0 takes the same-page path, zeroed entries match page 0,
  // replacement wraps after entry 3
  xlat_row_t directed_rows [14] = '{
    '{16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0, 8'h00, 8'h00}},
    '{16'h00FF, 1'b1, '{16'h00FF, 1'b1, 1'b0, 8'h00, 8'h00}},
    '{16'h0105, 1'b1, '{16'h0B05, 1'b0, 1'b1, 8'h01, 8'h0B}},
    '{16'h0000, 1'b1, '{16'h0C00, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{16'hFFFF, 1'b1, '{16'h0CFF, 1'b0, 1'b1, 8'hFF, 8'h0C}},
    '{16'hFF00, 1'b1, '{16'h0C00, 1'b1, 1'b0, 8'h00, 8'h00}},
    '{16'h0280, 1'b1, '{16'h0D80, 1'b0, 1'b1, 8'h02, 8'h0D}},
    '{16'h0300, 1'b1, '{16'h0E00, 1'b0, 1'b1, 8'h03, 8'h0E}},
    '{16'h0400, 1'b1, '{16'h0B00, 1'b0, 1'b1, 8'h04, 8'h0B}},
    '{16'h0101, 1'b1, '{16'h0C01, 1'b0, 1'b1, 8'h01, 8'h0C}},
    '{16'h0300, 1'b0, '{16'h0000, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{16'h5555, 1'b0, '{16'h0000, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{16'hAAAA, 1'b0, '{16'h0000, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{16'h0400, 1'b0, '{16'h0000, 1'b0, 1'b0, 8'h00, 8'h00}}
  };

  function automatic cpt_result_t translate_addr(input logic [15:0] addr);
    logic [7:0]  page;
    logic [7:0]  frame;
    logic        hit;
    cpt_result_t r;
    page  = addr[15:8];
    r     = '0;
    frame = 8'h00;
    if (page == prev_page) begin
      frame       = prev_frame;
      r.same_page = 1'b1;
    end else begin
      hit = 1'b0;
      for (int k = 0; k < ENTRIES; k++) begin
        if (!hit && page_tbl[k] == page) begin
          frame = frame_base_q + 8'(k);
          hit   = 1'b1;
        end
      end
      if (!hit) begin
        page_tbl[fill_ptr] = page;
        frame              = frame_base_q + 8'(fill_ptr);
        r.page_fault       = 1'b1;
        r.fill_source_page = page;
        r.fill_frame       = frame;
        fill_ptr           = (fill_ptr == ENTRIES - 1) ? 0 : fill_ptr + 1;
      end
      prev_page  = page;
      prev_frame = frame;
    end
    r.phys_addr = {frame, addr[7:0]};
    return r;
  endfunction

  // scoreboard: results are checked before the same-edge request is predicted
  always @(posedge clk) begin : scoreboard
    cpt_result_t got;
    cpt_result_t want;
    xlat_row_t   row;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.phys_addr, rsp_ch.same_page, rsp_ch.page_fault,
                rsp_ch.fill_source_page, rsp_ch.fill_frame};
        if (pending_xlat.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected word: phys=%h same=%b fault=%b src=%h frame=%h",
                     got.phys_addr, got.same_page, got.page_fault,
                     got.fill_source_page, got.fill_frame);
        end else begin
          want = pending_xlat.pop_front();
          if (got.phys_addr != want.phys_addr || got.same_page != want.same_page ||
              got.page_fault != want.page_fault ||
              got.fill_source_page != want.fill_source_page ||
              got.fill_frame != want.fill_frame) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: exp phys=%h same=%b fault=%b src=%h frame=%h | got phys=%h same=%b fault=%b src=%h frame=%h",
                       want.phys_addr, want.same_page, want.page_fault,
                       want.fill_source_page, want.fill_frame,
                       got.phys_addr, got.same_page, got.page_fault,
                       got.fill_source_page, got.fill_frame);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        row  = pinned_q.pop_front();
        want = translate_addr(req_ch.code_addr);
        if (row.pinned)
          want = row.res;
        pending_xlat.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready)
        frame_base_q = cfg_ch.data;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_req) begin
      rsp_ch.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no word moving anywhere
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance, valid still high
  task automatic send_addr(input logic [15:0] addr, input xlat_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pinned_q.push_back(row);
    req_ch.valid     <= 1'b1;
    req_ch.code_addr <= addr;
    last_sent_page    = addr[15:8];
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_words();
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_frame_base(input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly a working set a bit larger than the table, some repeats, some noise
  function automatic logic [15:0] pick_addr();
    logic [7:0] page;
    case ($urandom_range(3))
      0, 1:    page = page_pool[$urandom_range(POOL_PAGES - 1)];
      2:       page = last_sent_page;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
    return {page, 8'($urandom_range(255))};
  endfunction

  initial begin : stimulus
    logic [7:0] bases [PHASES];
    xlat_row_t  free_row;
    clk              = 1'b0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.code_addr = 16'h0000;
    rsp_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = 8'h00;
    hold_req         = 1'b0;
    mismatches       = 0;
    send_idle_pct    = 22;
    recv_idle_pct    = 61;
    last_sent_page   = 8'h00;
    for (int k = 0; k < ENTRIES; k++)
      page_tbl[k] = 8'h00;
    prev_page    = 8'h00;
    prev_frame   = 8'h00;
    fill_ptr     = 0;
    frame_base_q = FRAME_BASE_RESET;
    free_row     = '0;

    bases[0] = 8'd0;
    bases[1] = 8'd251;
    bases[2] = 8'($urandom_range(251));
    bases[3] = 8'($urandom_range(251));
    bases[4] = 8'($urandom_range(251));
    bases[5] = FRAME_BASE_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_addr(directed_rows[i].addr, directed_rows[i]);
    req_ch.valid <= 1'b0;
    drain_words();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 61;
      end else if (p < 4) begin
        send_idle_pct = 61;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_frame_base(bases[p]);
      for (int k = 0; k < POOL_PAGES; k++)
        page_pool[k] = 8'($urandom_range(255));
      if (p == 4)
        hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++)
        send_addr(pick_addr(), free_row);
      req_ch.valid <= 1'b0;
      drain_words();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_xlat.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
src/cpt_pkg.sv
src/cpt_ifs.sv
src/cpt_table.sv
src/cpt_seq.sv
src/code_page_translate_fifo.sv
sim/code_page_translate_fifo_test.sv
